// ----- rtl/core/mips_subset_execute_stage_top_macros.svh -----
// assertion macros for the mips subset execute stage checker
// expects clk and arst_n to be visible where a macro is used
`ifndef MIPS_SUBSET_EXECUTE_STAGE_TOP_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_STAGE_TOP_MACROS_SVH

// property checked on every rising edge outside reset
`define MSE_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never be true outside reset
`define MSE_NEVER(label, expr, msg) \
	`MSE_CHECK(label, !(expr), msg)

`endif

// ----- rtl/core/mse_pkg.sv -----
// types and codes shared by the mips subset execute stage and its checker
// no dependencies
`timescale 1ns / 1ps

package mse_pkg;

	typedef enum logic [2:0] {
		CLS_REG    = 3'd0,
		CLS_MEM    = 3'd1,
		CLS_BRANCH = 3'd2,
		CLS_JUMP   = 3'd3,
		CLS_NOP    = 3'd4,
		CLS_UNSUP  = 3'd5
	} instr_class_t;

	// primary opcodes, bits 31..26
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// function codes of the special opcode, bits 5..0
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_SLT  = 6'h2A;

	localparam logic [4:0] LINK_REG = 5'd31;

	typedef struct packed {
		logic [31:0] instr;
		logic [31:0] instr_pc;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
	} exe_req_t;

	typedef struct packed {
		logic [31:0]  alu_out;
		logic [4:0]   dest_reg;
		logic         reg_write;
		logic         mem_read;
		logic         store_en;
		logic [31:0]  store_data;
		logic         redirect;
		logic [31:0]  next_pc;
		instr_class_t instr_class;
		logic         branch_taken;
	} exe_rsp_t;

endpackage

// ----- rtl/core/mips_subset_execute_stage_top.sv -----
// execute stage for a mips32 integer subset: input register, decode/alu, result register
// depends on mse_pkg
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------
// request   | start, accepted when !busy | req (mse_pkg::exe_req_t)
// result    | done, one cycle, no stall  | rsp (mse_pkg::exe_rsp_t)
//
// one transaction per cycle; the request is captured in the input register and the result
// in the result register, which drives rsp
// the alu and target adders sit between the input and result registers
// busy stays low, so start may be held high every cycle
// arst_n clears the valid flags only; payload registers are not reset
// the result is shown for one cycle and is never held back

module mips_subset_execute_stage_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mse_pkg::exe_req_t req,
	output logic              done,
	output mse_pkg::exe_rsp_t rsp
);
	import mse_pkg::*;

	logic     valid_s1;
	exe_req_t req_s1;
	logic     done_s2;
	exe_rsp_t rsp_s2;
	exe_rsp_t rsp_d;

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] seq;
	logic [31:0] jtarget;
	logic [31:0] btarget;
	logic [31:0] addr;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign op   = req_s1.instr[31:26];
	assign fn   = req_s1.instr[5:0];
	assign rt   = req_s1.instr[20:16];
	assign rd   = req_s1.instr[15:11];
	assign sh   = req_s1.instr[10:6];
	assign imm  = req_s1.instr[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign zimm = {16'h0000, imm};
	assign a    = req_s1.rs_value;
	assign b    = req_s1.rt_value;
	assign seq  = req_s1.instr_pc + 32'd4;
	assign addr = a + simm;

	assign jtarget = {seq[31:28], req_s1.instr[25:0], 2'b00};
	// pc + 4 + offset*4 in one adder: the low two bits pass through, the +4 is a carry in
	assign btarget = {req_s1.instr_pc[31:2] + simm[29:0] + 30'd1, req_s1.instr_pc[1:0]};

	always_comb begin
		logic wr;
		rsp_d             = '0;
		rsp_d.next_pc     = seq;
		rsp_d.instr_class = CLS_UNSUP;
		wr                = 1'b0;
		case (op)
			OP_SPECIAL: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rd;
				wr                = 1'b1;
				case (fn)
					FN_ADD, FN_ADDU: rsp_d.alu_out = a + b;
					FN_SUB:          rsp_d.alu_out = a - b;
					FN_AND:          rsp_d.alu_out = a & b;
					FN_OR:           rsp_d.alu_out = a | b;
					FN_SLT:          rsp_d.alu_out = {31'd0, $signed(a) < $signed(b)};
					FN_SLL:          rsp_d.alu_out = b << sh;
					FN_SRL:          rsp_d.alu_out = b >> sh;
					FN_JR: begin
						rsp_d.instr_class = CLS_JUMP;
						rsp_d.dest_reg    = '0;
						rsp_d.redirect    = 1'b1;
						rsp_d.next_pc     = a;
						wr                = 1'b0;
					end
					default: begin
						rsp_d.instr_class = CLS_UNSUP;
						rsp_d.dest_reg    = '0;
						wr                = 1'b0;
					end
				endcase
				// all-zero word is sll r0 and counts as a nop
				if (req_s1.instr == 32'd0) begin
					rsp_d.instr_class = CLS_NOP;
					rsp_d.dest_reg    = '0;
					rsp_d.alu_out     = '0;
					wr                = 1'b0;
				end
			end
			OP_J: begin
				rsp_d.instr_class = CLS_JUMP;
				rsp_d.redirect    = 1'b1;
				rsp_d.next_pc     = jtarget;
			end
			OP_JAL: begin
				rsp_d.instr_class = CLS_JUMP;
				rsp_d.redirect    = 1'b1;
				rsp_d.next_pc     = jtarget;
				rsp_d.alu_out     = seq + 32'd4;
				rsp_d.dest_reg    = LINK_REG;
				wr                = 1'b1;
			end
			OP_BEQ, OP_BNE: begin
				rsp_d.instr_class  = CLS_BRANCH;
				rsp_d.branch_taken = (a == b) == (op == OP_BEQ);
				if (rsp_d.branch_taken) begin
					rsp_d.redirect = 1'b1;
					rsp_d.next_pc  = btarget;
				end
			end
			OP_ADDI, OP_ADDIU: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = addr;
				wr                = 1'b1;
			end
			OP_SLTI: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = {31'd0, $signed(a) < $signed(simm)};
				wr                = 1'b1;
			end
			OP_ANDI: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = a & zimm;
				wr                = 1'b1;
			end
			OP_ORI: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = a | zimm;
				wr                = 1'b1;
			end
			OP_XORI: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = a ^ zimm;
				wr                = 1'b1;
			end
			OP_LUI: begin
				rsp_d.instr_class = CLS_REG;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = {imm, 16'h0000};
				wr                = 1'b1;
			end
			OP_LW: begin
				rsp_d.instr_class = CLS_MEM;
				rsp_d.dest_reg    = rt;
				rsp_d.alu_out     = addr;
				rsp_d.mem_read    = 1'b1;
				wr                = 1'b1;
			end
			OP_SW: begin
				rsp_d.instr_class = CLS_MEM;
				rsp_d.alu_out     = addr;
				rsp_d.store_en    = 1'b1;
				rsp_d.store_data  = b;
			end
			default: begin
				rsp_d.instr_class = CLS_UNSUP;
			end
		endcase
		// writes to register zero are dropped
		rsp_d.reg_write = wr && (rsp_d.dest_reg != 5'd0);
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

endmodule

// ----- rtl/core/mse_checker.sv -----
// port-level checks for the mips subset execute stage, bound to the top level
// depends on mse_pkg and mips_subset_execute_stage_top_macros.svh
`timescale 1ns / 1ps

`include "mips_subset_execute_stage_top_macros.svh"

module mse_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input mse_pkg::exe_req_t req,
	input logic              done,
	input mse_pkg::exe_rsp_t rsp
);
	import mse_pkg::*;

	// every accepted transaction gives its result, through the input and result registers
	`MSE_CHECK(a_result_follows, start && !busy |-> ##2 done, "accepted transaction lost")

	// no result without an accepted transaction before it
	`MSE_CHECK(a_no_spurious, done |-> $past(start && !busy, 2), "result without transaction")

	// fall-through next pc matches the pc of the transaction that caused it
	`MSE_CHECK(a_seq_pc, done && !rsp.redirect |-> rsp.next_pc == $past(req.instr_pc, 2) + 32'd4, "bad sequential next pc")

	// store and load flags only on memory class, never write to register zero
	`MSE_NEVER(a_mem_class, done && (rsp.store_en || rsp.mem_read) && rsp.instr_class != CLS_MEM, "memory flag outside memory class")

	`MSE_NEVER(a_r0_write, done && rsp.reg_write && rsp.dest_reg == 5'd0, "write to register zero")

endmodule

bind mips_subset_execute_stage_top mse_checker u_mse_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
